FILE: hdl/knn_pkg.sv
// Shared types, codes and helpers for the brute-force k-nearest-neighbor table.
// No dependencies; every other file of the block refers to this package.
package knn_pkg;

  localparam int CAPACITY_DEF     = 64;
  localparam int MAX_FEATURES_DEF = 8;
  localparam int MAX_CLASSES_DEF  = 8;
  localparam int MAX_K_DEF        = 8;

  localparam int ELEM_W    = 3;
  localparam int ELEMS     = 8;
  localparam int DATA_W    = 16;
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CNT4_W    = 4;
  localparam int TERM_W    = 32;
  localparam int ACC_W     = 35;
  localparam int ROOT_W    = 18;
  localparam int DIST_W    = 19;

  localparam logic [DIST_W-1:0] DIST_MAX = 19'd524280;

  localparam logic [CNT4_W-1:0] FEATURE_COUNT_RST  = 4'd8;
  localparam logic [CNT4_W-1:0] CLASS_COUNT_RST    = 4'd1;
  localparam logic [CNT4_W-1:0] NEIGHBOR_COUNT_RST = 4'd5;

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_DELETE,
    OP_QUERY,
    OP_NONE
  } op_t;

  typedef enum logic [2:0] {
    ST_INSERTED,
    ST_DUPLICATE,
    ST_FULL,
    ST_DELETED,
    ST_NOT_FOUND,
    ST_NEIGHBOR
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FEATURE_COUNT,
    CFG_CLASS_COUNT,
    CFG_NEIGHBOR_COUNT,
    CFG_DISTANCE_MODE,
    CFG_REJECT_DUPLICATES
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_SQRT,
    S_RANK,
    S_WRITE,
    S_COPY,
    S_COPY_END,
    S_STATUS,
    S_OUT_RD,
    S_OUT_LD,
    S_FINISH
  } state_t;

  function automatic logic [CNT4_W-1:0] clamp_cnt(input logic [CNT4_W-1:0] v,
                                                  input logic [CNT4_W-1:0] hi);
    logic [CNT4_W-1:0] r;
    r = v;
    if (v == '0) r = 4'd1;
    else if (v > hi) r = hi;
    return r;
  endfunction

  function automatic logic [DIST_W-1:0] sat_dist(input logic [ACC_W-1:0] v);
    logic [DIST_W-1:0] r;
    r = v[DIST_W-1:0];
    if (v > ACC_W'(DIST_MAX)) r = DIST_MAX;
    return r;
  endfunction

endpackage

FILE: hdl/knn_mem.sv
// Instance store: feature and class memories, one write and one read port each,
// registered read data. Depends on knn_pkg.
module knn_mem #(
  parameter int ADDR_W = knn_pkg::ELEM_W + 6
) (
  input  logic                               clk,
  input  logic                               we,
  input  logic [ADDR_W-1:0]                  waddr,
  input  logic signed [knn_pkg::DATA_W-1:0]  wdata_f,
  input  logic signed [knn_pkg::DATA_W-1:0]  wdata_c,
  input  logic                               re,
  input  logic [ADDR_W-1:0]                  raddr,
  output logic signed [knn_pkg::DATA_W-1:0]  rdata_f,
  output logic signed [knn_pkg::DATA_W-1:0]  rdata_c
);

  logic signed [knn_pkg::DATA_W-1:0] feat_mem [2**ADDR_W];
  logic signed [knn_pkg::DATA_W-1:0] class_mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      feat_mem[waddr]  <= wdata_f;
      class_mem[waddr] <= wdata_c;
    end
    if (re) begin
      rdata_f <= feat_mem[raddr];
      rdata_c <= class_mem[raddr];
    end
  end

endmodule

FILE: hdl/knn_isqrt.sv
// Iterative integer square root, one result bit per cycle.
// Depends on knn_pkg for the radicand and root widths.
module knn_isqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [knn_pkg::ACC_W-1:0]  radicand,
  output logic                       busy,
  output logic [knn_pkg::ROOT_W-1:0] root
);

  localparam int RAD_W = 2 * knn_pkg::ROOT_W;
  localparam int REM_W = knn_pkg::ROOT_W + 3;
  localparam int CNT_W = $clog2(knn_pkg::ROOT_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [RAD_W-1:0] x;
  logic [REM_W-1:0] rem;
  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic             fits;

  always_comb begin
    rem_sh = {rem[REM_W-3:0], x[RAD_W-1 -: 2]};
    trial  = {1'b0, root, 2'b01};
    fits   = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(knn_pkg::ROOT_W);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x    <= RAD_W'(radicand);
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      x    <= {x[RAD_W-3:0], 2'b00};
      rem  <= fits ? rem_sh - trial : rem_sh;
      root <= {root[knn_pkg::ROOT_W-2:0], fits};
    end
  end

endmodule

FILE: hdl/brute_force_knn_table.sv
// Top level of the brute-force k-nearest-neighbor table: request sequencer,
// distance datapath and top-k list. Depends on knn_pkg, knn_mem, knn_isqrt.
//
// Requests come in as element beats on the req channel (req_valid/req_stall);
// the beat with last_element set ends the request and carries req_type.
// Results leave on the res channel (res_valid/res_stall) from an output
// register; last_result marks the final beat of a request.
// Non-final beats are taken one per cycle. Once a request closes, req_stall
// stays high until its last result, if it has one, is loaded into the output register.
// Insert: one table write per element slot, plus a duplicate scan when enabled.
// Delete: a scan up to the match, then each later entry is copied down one slot.
// Scan: each entry's feature_count elements are read through the single memory
// read port; a query adds a top-k update per entry, and in Euclidean mode a
// bit-serial square root.
// Query output: each result beat is read from the table, then loaded into the
// output register; k * max(feature_count, class_count) beats.
// Reset empties the table and restores register defaults; no clearing pass.
// A stalled receiver holds the output register and the sequencer waits on it.
module brute_force_knn_table #(
  parameter int CAPACITY     = knn_pkg::CAPACITY_DEF,
  parameter int MAX_FEATURES = knn_pkg::MAX_FEATURES_DEF,
  parameter int MAX_CLASSES  = knn_pkg::MAX_CLASSES_DEF,
  parameter int MAX_K        = knn_pkg::MAX_K_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [knn_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [knn_pkg::CFG_W-1:0]             cfg_data,
  input  logic                                  req_valid,
  output logic                                  req_stall,
  input  logic [1:0]                            req_type,
  input  logic signed [knn_pkg::DATA_W-1:0]     feature_value,
  input  logic signed [knn_pkg::DATA_W-1:0]     class_value,
  input  logic                                  last_element,
  output logic                                  res_valid,
  input  logic                                  res_stall,
  output logic [2:0]                            status,
  output logic [2:0]                            rank,
  output logic [2:0]                            element_index,
  output logic                                  neighbor_valid,
  output logic signed [knn_pkg::DATA_W-1:0]     feature_out,
  output logic signed [knn_pkg::DATA_W-1:0]     class_out,
  output logic [knn_pkg::DIST_W-1:0]            distance,
  output logic                                  last_result
);

  localparam int POS_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int ADDR_W = POS_W + knn_pkg::ELEM_W;
  localparam int KI_W   = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int DW     = knn_pkg::DATA_W;
  localparam int EW     = knn_pkg::ELEM_W;
  localparam int C4     = knn_pkg::CNT4_W;

  // configuration
  logic [C4-1:0] cfg_fc, cfg_cc, cfg_k;
  logic          cfg_mode, cfg_reject;
  logic [C4-1:0] fc, cc, kk, elems;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_fc     <= knn_pkg::FEATURE_COUNT_RST;
      cfg_cc     <= knn_pkg::CLASS_COUNT_RST;
      cfg_k      <= knn_pkg::NEIGHBOR_COUNT_RST;
      cfg_mode   <= 1'b0;
      cfg_reject <= 1'b0;
    end else if (cfg_we) begin
      unique case (knn_pkg::cfg_reg_t'(cfg_index))
        knn_pkg::CFG_FEATURE_COUNT:     cfg_fc     <= cfg_data;
        knn_pkg::CFG_CLASS_COUNT:       cfg_cc     <= cfg_data;
        knn_pkg::CFG_NEIGHBOR_COUNT:    cfg_k      <= cfg_data;
        knn_pkg::CFG_DISTANCE_MODE:     cfg_mode   <= cfg_data[0];
        knn_pkg::CFG_REJECT_DUPLICATES: cfg_reject <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    fc    = knn_pkg::clamp_cnt(cfg_fc, C4'(MAX_FEATURES));
    cc    = knn_pkg::clamp_cnt(cfg_cc, C4'(MAX_CLASSES));
    kk    = knn_pkg::clamp_cnt(cfg_k, C4'(MAX_K));
    elems = (fc > cc) ? fc : cc;
  end

  // control state
  knn_pkg::state_t  state, state_next;
  knn_pkg::op_t     op;
  knn_pkg::status_t stat;
  logic [CNT_W-1:0] count, i, i_inc, i_dec;
  logic [EW-1:0]    e, elem_cnt;
  logic [2:0]       r;
  logic [C4-1:0]    found;

  logic signed [DW-1:0] req_f [knn_pkg::ELEMS];
  logic signed [DW-1:0] req_c [knn_pkg::ELEMS];

  // memory port
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic signed [DW-1:0] mem_wf, mem_wc, mem_rf, mem_rc;
  logic              cp_v;
  logic [ADDR_W-1:0] cp_addr;

  // scan datapath
  logic                       rd_v, term_v, term_eq, eq;
  logic [EW-1:0]              rd_e;
  logic [knn_pkg::TERM_W-1:0] term;
  logic [knn_pkg::ACC_W-1:0]  acc;
  logic signed [DW:0]         diff, diff_abs;
  logic [DW-1:0]              absd;

  // square root
  logic                       sq_start, sq_busy;
  logic [knn_pkg::ROOT_W-1:0] sq_root;

  // top-k list
  logic [knn_pkg::DIST_W-1:0] best_dist [MAX_K];
  logic [POS_W-1:0]           best_pos [MAX_K];
  logic [MAX_K-1:0]           le;
  logic [knn_pkg::DIST_W-1:0] dist_cur;
  logic [C4-1:0]              km1;
  logic                       do_ins;
  logic [KI_W-1:0]            r_i;

  // handshake and flags
  logic req_acc, out_free, scan_done, clear;
  logic e_last_scan, e_last_out, r_last, i_last, full, r_ok;

  knn_pkg::status_t res_status;

  always_comb begin
    req_stall   = (state != knn_pkg::S_IDLE);
    req_acc     = req_valid && !req_stall;
    out_free    = !res_valid || !res_stall;
    scan_done   = (state == knn_pkg::S_DRAIN) && !rd_v && !term_v;
    i_inc       = i + CNT_W'(1);
    i_dec       = i - CNT_W'(1);
    i_last      = (i_inc == count);
    full        = (count >= CNT_W'(CAPACITY));
    e_last_scan = ({1'b0, e} == fc - C4'(1));
    e_last_out  = ({1'b0, e} == elems - C4'(1));
    r_last      = ({1'b0, r} == kk - C4'(1));
    r_i         = r[KI_W-1:0];
    r_ok        = ({1'b0, r} < found);
    km1         = kk - C4'(1);
    dist_cur    = knn_pkg::sat_dist(cfg_mode ? acc : knn_pkg::ACC_W'(sq_root));
    do_ins      = (found < kk) || (dist_cur < best_dist[km1[KI_W-1:0]]);
    clear       = (state != knn_pkg::S_IDLE) && (state_next == knn_pkg::S_IDLE);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      knn_pkg::S_IDLE: begin
        if (req_acc && last_element) begin
          unique case (knn_pkg::op_t'(req_type))
            knn_pkg::OP_INSERT: begin
              if (cfg_reject && count != '0) state_next = knn_pkg::S_SCAN;
              else if (full) state_next = knn_pkg::S_STATUS;
              else state_next = knn_pkg::S_WRITE;
            end
            knn_pkg::OP_DELETE:
              state_next = (count != '0) ? knn_pkg::S_SCAN : knn_pkg::S_STATUS;
            knn_pkg::OP_QUERY:
              state_next = (count != '0) ? knn_pkg::S_SCAN : knn_pkg::S_OUT_RD;
            knn_pkg::OP_NONE: state_next = knn_pkg::S_FINISH;
          endcase
        end
      end
      knn_pkg::S_SCAN: if (e_last_scan) state_next = knn_pkg::S_DRAIN;
      knn_pkg::S_DRAIN: begin
        if (scan_done) begin
          unique case (op)
            knn_pkg::OP_INSERT: begin
              if (eq) state_next = knn_pkg::S_STATUS;
              else if (!i_last) state_next = knn_pkg::S_SCAN;
              else if (full) state_next = knn_pkg::S_STATUS;
              else state_next = knn_pkg::S_WRITE;
            end
            knn_pkg::OP_DELETE: begin
              if (eq) state_next = i_last ? knn_pkg::S_COPY_END : knn_pkg::S_COPY;
              else state_next = i_last ? knn_pkg::S_STATUS : knn_pkg::S_SCAN;
            end
            knn_pkg::OP_QUERY:
              state_next = cfg_mode ? knn_pkg::S_RANK : knn_pkg::S_SQRT;
            knn_pkg::OP_NONE: state_next = knn_pkg::S_FINISH;
          endcase
        end
      end
      knn_pkg::S_SQRT: if (!sq_busy) state_next = knn_pkg::S_RANK;
      knn_pkg::S_RANK: state_next = i_last ? knn_pkg::S_OUT_RD : knn_pkg::S_SCAN;
      knn_pkg::S_WRITE: if (e == '1) state_next = knn_pkg::S_STATUS;
      knn_pkg::S_COPY: if (e == '1 && i_last) state_next = knn_pkg::S_COPY_END;
      knn_pkg::S_COPY_END: state_next = knn_pkg::S_STATUS;
      knn_pkg::S_STATUS: if (out_free) state_next = knn_pkg::S_IDLE;
      knn_pkg::S_OUT_RD: state_next = knn_pkg::S_OUT_LD;
      knn_pkg::S_OUT_LD: begin
        if (out_free) state_next = (r_last && e_last_out) ? knn_pkg::S_IDLE
                                                          : knn_pkg::S_OUT_RD;
      end
      knn_pkg::S_FINISH: state_next = knn_pkg::S_IDLE;
      default: state_next = knn_pkg::S_IDLE;
    endcase
  end

  // memory port and sqrt start
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = {i[POS_W-1:0], e};
    mem_we    = 1'b0;
    mem_waddr = cp_addr;
    mem_wf    = mem_rf;
    mem_wc    = mem_rc;
    unique case (state)
      knn_pkg::S_SCAN, knn_pkg::S_COPY: mem_re = 1'b1;
      knn_pkg::S_OUT_RD: begin
        mem_re    = 1'b1;
        mem_raddr = {best_pos[r_i], e};
      end
      knn_pkg::S_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = {count[POS_W-1:0], e};
        mem_wf    = req_f[e];
        mem_wc    = req_c[e];
      end
      default: ;
    endcase
    if (cp_v) mem_we = 1'b1;
    sq_start = scan_done && (op == knn_pkg::OP_QUERY) && !cfg_mode;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= knn_pkg::S_IDLE;
    else state <= state_next;
  end

  // counters, table size, status code
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      i     <= '0;
      e     <= '0;
      r     <= '0;
      found <= '0;
      op    <= knn_pkg::OP_NONE;
      stat  <= knn_pkg::ST_INSERTED;
      cp_v  <= 1'b0;
    end else begin
      cp_v <= (state == knn_pkg::S_COPY);
      unique case (state)
        knn_pkg::S_IDLE: begin
          if (req_acc && last_element) begin
            op    <= knn_pkg::op_t'(req_type);
            i     <= '0;
            e     <= '0;
            r     <= '0;
            found <= '0;
            if (knn_pkg::op_t'(req_type) == knn_pkg::OP_DELETE)
              stat <= knn_pkg::ST_NOT_FOUND;
            else stat <= knn_pkg::ST_FULL;
          end
        end
        knn_pkg::S_SCAN: e <= e_last_scan ? '0 : e + EW'(1);
        knn_pkg::S_DRAIN: begin
          if (scan_done && op != knn_pkg::OP_QUERY) begin
            i <= i_inc;
            if (op == knn_pkg::OP_INSERT && eq) stat <= knn_pkg::ST_DUPLICATE;
          end
        end
        knn_pkg::S_RANK: begin
          i <= i_inc;
          if (do_ins && found < kk) found <= found + C4'(1);
        end
        knn_pkg::S_WRITE: begin
          e <= e + EW'(1);
          if (e == '1) begin
            count <= count + CNT_W'(1);
            stat  <= knn_pkg::ST_INSERTED;
          end
        end
        knn_pkg::S_COPY: begin
          e <= e + EW'(1);
          if (e == '1) i <= i_inc;
        end
        knn_pkg::S_COPY_END: begin
          count <= count - CNT_W'(1);
          stat  <= knn_pkg::ST_DELETED;
        end
        knn_pkg::S_OUT_LD: begin
          if (out_free) begin
            if (e_last_out) begin
              e <= '0;
              r <= r + 3'd1;
            end else begin
              e <= e + EW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == knn_pkg::S_COPY) cp_addr <= {i_dec[POS_W-1:0], e};
  end

  // request buffer
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      elem_cnt <= '0;
      for (int n = 0; n < knn_pkg::ELEMS; n++) begin
        req_f[n] <= '0;
        req_c[n] <= '0;
      end
    end else if (req_acc) begin
      elem_cnt <= elem_cnt + EW'(1);
      if ({1'b0, elem_cnt} < C4'(MAX_FEATURES)) req_f[elem_cnt] <= feature_value;
      if ({1'b0, elem_cnt} < C4'(MAX_CLASSES)) req_c[elem_cnt] <= class_value;
    end
  end

  // distance and match pipeline
  always_comb begin
    diff     = $signed({mem_rf[DW-1], mem_rf}) - $signed({req_f[rd_e][DW-1], req_f[rd_e]});
    diff_abs = diff[DW] ? -diff : diff;
    absd     = diff_abs[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v   <= 1'b0;
      term_v <= 1'b0;
    end else begin
      rd_v   <= (state == knn_pkg::S_SCAN);
      term_v <= rd_v;
    end
  end

  always_ff @(posedge clk) begin
    rd_e    <= e;
    term    <= cfg_mode ? knn_pkg::TERM_W'(absd) : absd * absd;
    term_eq <= (mem_rf == req_f[rd_e]);
    if (state == knn_pkg::S_SCAN && e == '0) begin
      acc <= '0;
      eq  <= 1'b1;
    end else if (term_v) begin
      acc <= acc + knn_pkg::ACC_W'(term);
      eq  <= eq & term_eq;
    end
  end

  // top-k insertion, one entry in each S_RANK state
  genvar p;
  generate
    for (p = 0; p < MAX_K; p++) begin : g_best
      assign le[p] = (C4'(p) < found) && (best_dist[p] <= dist_cur);
      always_ff @(posedge clk) begin
        if (state == knn_pkg::S_RANK && do_ins && !le[p]) begin
          if (p == 0) begin
            best_dist[p] <= dist_cur;
            best_pos[p]  <= i[POS_W-1:0];
          end else if (le[(p > 0) ? p - 1 : 0]) begin
            best_dist[p] <= dist_cur;
            best_pos[p]  <= i[POS_W-1:0];
          end else begin
            best_dist[p] <= best_dist[(p > 0) ? p - 1 : 0];
            best_pos[p]  <= best_pos[(p > 0) ? p - 1 : 0];
          end
        end
      end
    end
  endgenerate

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if ((state == knn_pkg::S_STATUS || state == knn_pkg::S_OUT_LD) && out_free) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == knn_pkg::S_STATUS && out_free) begin
      res_status     <= stat;
      rank           <= '0;
      element_index  <= '0;
      neighbor_valid <= 1'b0;
      feature_out    <= '0;
      class_out      <= '0;
      distance       <= '0;
      last_result    <= 1'b1;
    end else if (state == knn_pkg::S_OUT_LD && out_free) begin
      res_status     <= knn_pkg::ST_NEIGHBOR;
      rank           <= r;
      element_index  <= e;
      neighbor_valid <= r_ok;
      feature_out    <= (r_ok && {1'b0, e} < fc) ? mem_rf : '0;
      class_out      <= (r_ok && {1'b0, e} < cc) ? mem_rc : '0;
      distance       <= r_ok ? best_dist[r_i] : '0;
      last_result    <= r_last && e_last_out;
    end
  end

  assign status = res_status;

  knn_mem #(
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata_f (mem_wf),
    .wdata_c (mem_wc),
    .re      (mem_re),
    .raddr   (mem_raddr),
    .rdata_f (mem_rf),
    .rdata_c (mem_rc)
  );

  knn_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (acc),
    .busy     (sq_busy),
    .root     (sq_root)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_found_bound: assert property (@(posedge clk) disable iff (rst)
    found <= C4'(MAX_K))
    else $error("top-k list overfilled");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_status != knn_pkg::ST_NEIGHBOR |-> last_result)
    else $error("status beat not marked last");

  a_mem_port: assert property (@(posedge clk) disable iff (rst)
    !(mem_we && mem_re && mem_waddr == mem_raddr))
    else $error("read and write on the same table entry");

endmodule
